[rtl/core/merge_sorter_defines.svh]
// ----------------------------------------------------------------------------
// merge_sorter_defines.svh
// Assertion macros shared by the merge sorter RTL.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORTER_DEFINES_SVH
`define MERGE_SORTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ms_pkg.sv]
// ----------------------------------------------------------------------------
// ms_pkg
// Shared types and constants of the merge sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ms_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int WORD_W    = 32;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam cnt_t MAX_CNT = cnt_t'(MAX_ITEMS);

  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } ram_wr_t;

endpackage

[rtl/core/ms_ram.sv]
// ----------------------------------------------------------------------------
// ms_ram
// Element memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ms_ram (
  input  logic            clk_i,
  input  ms_pkg::ram_wr_t wr_i,
  input  ms_pkg::addr_t   raddr_a_i,
  input  ms_pkg::addr_t   raddr_b_i,
  output ms_pkg::word_t   rdata_a_o,
  output ms_pkg::word_t   rdata_b_o
);
  import ms_pkg::*;

  word_t mem [MAX_ITEMS];
  word_t rdata_a_q;
  word_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/core/merge_sorter.sv]
// ----------------------------------------------------------------------------
// merge_sorter
// Batch merge sort of signed 32-bit values, ascending and stable.
//
// Channel  Direction  Handshake                 Payload
// input    in         start_i & !busy_o         value_i, last_i
// result   out        res_valid_o (one cycle)   value_res_o, last_res_o, dropped_o
//
// Loading writes each value into mem0 while it has room. A batch of n items then
// runs ceil(log2 n) bottom-up merge passes, one element per cycle through the
// dual-read source memory, ping-ponging between two RAMs.
// Output gives one result per cycle after a registered read.
// Reset clears control state only; the memories hold no reset value.
// busy_o rises after the closing transaction and drops with the final result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "merge_sorter_defines.svh"

module merge_sorter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ms_pkg::word_t value_i,
  input  logic          last_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output ms_pkg::word_t value_res_o,
  output logic          last_res_o,
  output logic          dropped_o
);
  import ms_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MERGE,
    ST_OPRIME,
    ST_OUT
  } state_e;

  state_e  state_q, state_d;
  cnt_t    cnt_q, cnt_d;
  logic    ovf_q, ovf_d;
  logic    sel_q, sel_d;
  cnt_t    wid_q, wid_d;
  cnt_t    i_q, i_d;
  cnt_t    j_q, j_d;
  cnt_t    k_q, k_d;
  cnt_t    mid_q, mid_d;
  cnt_t    hi_q, hi_d;
  logic    res_valid_q, res_valid_d;
  word_t   value_res_q, value_res_d;
  logic    last_res_q, last_res_d;
  logic    dropped_q, dropped_d;

  ram_wr_t wr0, wr1;
  word_t   rd0_a, rd0_b, rd1_a, rd1_b;
  word_t   rd_a, rd_b;
  logic    take_left;
  logic [CNT_W:0] mid_sum, hi_sum;
  cnt_t    wid_nxt;

  function automatic cnt_t clip(logic [CNT_W:0] s, cnt_t n);
    return (s > {1'b0, n}) ? n : s[CNT_W-1:0];
  endfunction

  // sel_q = 0: mem0 is the merge source, mem1 the destination
  assign rd_a = sel_q ? rd1_a : rd0_a;
  assign rd_b = sel_q ? rd1_b : rd0_b;

  assign take_left = (i_q < mid_q) && ((j_q >= hi_q) || (rd_a <= rd_b));
  assign mid_sum   = {1'b0, hi_q} + {1'b0, wid_q};
  assign hi_sum    = mid_sum + {1'b0, wid_q};
  assign wid_nxt   = cnt_t'({wid_q, 1'b0});

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    sel_d       = sel_q;
    wid_d       = wid_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    res_valid_d = 1'b0;
    value_res_d = value_res_q;
    last_res_d  = last_res_q;
    dropped_d   = dropped_q;
    wr0         = '0;
    wr1         = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (cnt_q < MAX_CNT) begin
            wr0.en   = 1'b1;
            wr0.addr = cnt_q[ADDR_W-1:0];
            wr0.data = value_i;
            cnt_d    = cnt_q + cnt_t'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            sel_d = 1'b0;
            i_d   = '0;
            k_d   = '0;
            wid_d = cnt_t'(1);
            j_d   = clip((CNT_W+1)'(1), cnt_d);
            mid_d = clip((CNT_W+1)'(1), cnt_d);
            hi_d  = clip((CNT_W+1)'(2), cnt_d);
            state_d = (cnt_d == cnt_t'(1)) ? ST_OPRIME : ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (sel_q) begin
          wr0.en   = 1'b1;
          wr0.addr = k_q[ADDR_W-1:0];
          wr0.data = take_left ? rd_a : rd_b;
        end else begin
          wr1.en   = 1'b1;
          wr1.addr = k_q[ADDR_W-1:0];
          wr1.data = take_left ? rd_a : rd_b;
        end
        if (take_left) begin
          i_d = i_q + cnt_t'(1);
        end else begin
          j_d = j_q + cnt_t'(1);
        end
        k_d = k_q + cnt_t'(1);
        if (k_d == cnt_q) begin
          // pass done, destination becomes the next source
          sel_d = ~sel_q;
          i_d   = '0;
          k_d   = '0;
          if (wid_nxt < cnt_q) begin
            wid_d   = wid_nxt;
            j_d     = clip({1'b0, wid_nxt}, cnt_q);
            mid_d   = clip({1'b0, wid_nxt}, cnt_q);
            hi_d    = clip({wid_nxt, 1'b0}, cnt_q);
            state_d = ST_PRIME;
          end else begin
            state_d = ST_OPRIME;
          end
        end else if (k_d == hi_q) begin
          i_d   = hi_q;
          j_d   = clip(mid_sum, cnt_q);
          mid_d = clip(mid_sum, cnt_q);
          hi_d  = clip(hi_sum, cnt_q);
        end
      end
      ST_OPRIME: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        res_valid_d = 1'b1;
        value_res_d = rd_a;
        last_res_d  = (i_q + cnt_t'(1)) == cnt_q;
        dropped_d   = ovf_q;
        i_d         = i_q + cnt_t'(1);
        if ((i_q + cnt_t'(1)) == cnt_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      sel_q       <= 1'b0;
      wid_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      res_valid_q <= 1'b0;
      value_res_q <= '0;
      last_res_q  <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      sel_q       <= sel_d;
      wid_q       <= wid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      res_valid_q <= res_valid_d;
      value_res_q <= value_res_d;
      last_res_q  <= last_res_d;
      dropped_q   <= dropped_d;
    end
  end

  ms_ram u_mem0 (
    .clk_i     (clk_i),
    .wr_i      (wr0),
    .raddr_a_i (i_d[ADDR_W-1:0]),
    .raddr_b_i (j_d[ADDR_W-1:0]),
    .rdata_a_o (rd0_a),
    .rdata_b_o (rd0_b)
  );

  ms_ram u_mem1 (
    .clk_i     (clk_i),
    .wr_i      (wr1),
    .raddr_a_i (i_d[ADDR_W-1:0]),
    .raddr_b_i (j_d[ADDR_W-1:0]),
    .rdata_a_o (rd1_a),
    .rdata_b_o (rd1_b)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign value_res_o = value_res_q;
  assign last_res_o  = last_res_q;
  assign dropped_o   = dropped_q;

  `MS_ASSERT_NOW(a_merge_in_range, state_q == ST_MERGE,
                 (k_q < cnt_q) && (wid_q < cnt_q), "merge index out of batch")
  `MS_ASSERT_NOW(a_run_bounds, state_q == ST_MERGE,
                 (i_q <= mid_q) && (j_q <= hi_q) && (mid_q <= hi_q), "run pointer overrun")
  `MS_ASSERT_NOW(a_count_cap, 1'b1, cnt_q <= MAX_CNT, "item count above capacity")
  `MS_ASSERT_NEXT(a_close_busy, start_i && !busy_o && last_i, busy_o,
                  "closing transaction did not start the sort")

endmodule
